[hdl/sha512_pkg.sv]
// ----------------------------------------------------------------------------
// sha512_pkg
// types, round constants and helpers shared by the hasher modules
// ----------------------------------------------------------------------------
package sha512_pkg;

    localparam int BLOCK_BYTES = 128;
    localparam int FILL_W      = $clog2(BLOCK_BYTES);
    localparam int ROUNDS      = 80;
    localparam int ROUND_W     = $clog2(ROUNDS);

    localparam logic [FILL_W-1:0]  FILL_FULL  = FILL_W'(BLOCK_BYTES - 1);
    localparam logic [FILL_W-1:0]  FILL_LEN   = FILL_W'(BLOCK_BYTES - 16);
    localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);
    localparam logic [7:0]         PAD_BYTE   = 8'h80;

    typedef enum logic [1:0] {
        BSEL_MSG  = 2'd0,
        BSEL_PAD  = 2'd1,
        BSEL_ZERO = 2'd2
    } byte_sel_t;

    typedef struct packed {
        logic      push_byte;
        byte_sel_t byte_sel;
        logic      push_len_hi;
        logic      push_len_lo;
        logic      capture_rest;
        logic      comp_load;
        logic      comp_round;
        logic      comp_add;
        logic      count_block;
        logic      out_next;
        logic      reinit;
    } dp_cmd_t;

    typedef struct packed {
        logic fill_full;
        logic fill_len;
        logic round_last;
        logic out_last;
    } dp_status_t;

    function automatic logic [63:0] iv_word(input logic [2:0] idx);
        logic [63:0] v;
        unique case (idx)
            3'd0: v = 64'h6a09e667f3bcc908;
            3'd1: v = 64'hbb67ae8584caa73b;
            3'd2: v = 64'h3c6ef372fe94f82b;
            3'd3: v = 64'ha54ff53a5f1d36f1;
            3'd4: v = 64'h510e527fade682d1;
            3'd5: v = 64'h9b05688c2b3e6c1f;
            3'd6: v = 64'h1f83d9abfb41bd6b;
            default: v = 64'h5be0cd19137e2179;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] round_k(input logic [ROUND_W-1:0] idx);
        logic [63:0] k;
        unique case (idx)
            7'd0:  k = 64'h428a2f98d728ae22; 7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f; 7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538; 7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b; 7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242; 7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

    function automatic logic [63:0] rotr64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

endpackage

[hdl/sha512_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha512_stream_hasher
// sha-512 over a byte stream, digest returned as eight 64-bit words
// ----------------------------------------------------------------------------
// usage:
//   input channel s_axis: one word per message byte (tuser set) or an end-only
//   word (tuser clear); tlast finalizes the message after any byte it carries.
//   output channel m_axis: eight digest words h0..h7 per message, tuser holds
//   the word index and tlast marks h7.
// sequence:
//   every 128th byte starts a compression (load, 80 rounds on the single
//   round unit, chain add). finalization pushes the 0x80 pad and zero fill
//   one byte per cycle up to byte 112, sees the length slot reached, pushes
//   the two length words, compresses one or two blocks, then gives the
//   eight digest words, one per cycle while m_axis_tready is high.
//   one message item is worked on at a time: s_axis_tready is low from the
//   cycle after an accepted word that fills a block or ends the message
//   until that word's work is done.
// reset:
//   rst_n clears the controller, the fill level and the block count, and loads
//   the initial hash value; the block buffer holds no valid state until filled.
// stall:
//   a low m_axis_tready holds the current digest word and index steady and
//   keeps s_axis_tready low until h7 has been taken.
// ----------------------------------------------------------------------------
module sha512_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // msg_byte[7:0]
    input  logic        s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // digest_word[63:0]
    output logic [2:0]  m_axis_tuser,   // word_index[2:0]
    output logic        m_axis_tlast    // last_word
);
    import sha512_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: decides which byte or word enters and when rounds run
    sha512_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_present (s_axis_tuser),
        .in_end     (s_axis_tlast),
        .in_ready   (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .status     (status),
        .cmd        (cmd)
    );

    // datapath: schedule window doubles as the block buffer
    sha512_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (s_axis_tdata),
        .cmd         (cmd),
        .status      (status),
        .digest_word (m_axis_tdata),
        .word_index  (m_axis_tuser),
        .last_word   (m_axis_tlast)
    );

endmodule

[hdl/sha512_ctrl.sv]
// ----------------------------------------------------------------------------
// sha512_ctrl
// sequencer: byte intake, padding, compression passes and digest readout
// ----------------------------------------------------------------------------
module sha512_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_present,
    input  logic                   in_end,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  sha512_pkg::dp_status_t status,
    output sha512_pkg::dp_cmd_t    cmd
);
    import sha512_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_PAD80 = 10'b0000000010,
        ST_PADZ  = 10'b0000000100,
        ST_LENHI = 10'b0000001000,
        ST_LENLO = 10'b0000010000,
        ST_LOAD  = 10'b0000100000,
        ST_ROUND = 10'b0001000000,
        ST_ADD   = 10'b0010000000,
        ST_OUT   = 10'b0100000000,
        ST_SPARE = 10'b1000000000
    } state_t;

    typedef enum logic [1:0] {
        RET_IDLE  = 2'd0,
        RET_PAD80 = 2'd1,
        RET_PADZ  = 2'd2,
        RET_OUT   = 2'd3
    } ret_t;

    state_t state_reg, state_next;
    ret_t   ret_reg, ret_next;
    logic   count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= RET_IDLE;
            count_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            count_reg <= count_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        count_next = count_reg;
        cmd        = '0;
        cmd.byte_sel = BSEL_MSG;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.push_byte = in_present;
                    if (in_present && status.fill_full)
                    begin
                        state_next = ST_LOAD;
                        count_next = 1'b1;
                        ret_next   = in_end ? RET_PAD80 : RET_IDLE;
                    end
                    else if (in_end)
                    begin
                        state_next = ST_PAD80;
                    end
                end
            end
            ST_PAD80:
            begin
                cmd.capture_rest = 1'b1;
                cmd.push_byte    = 1'b1;
                cmd.byte_sel     = BSEL_PAD;
                if (status.fill_full)
                begin
                    state_next = ST_LOAD;
                    count_next = 1'b0;
                    ret_next   = RET_PADZ;
                end
                else
                begin
                    state_next = ST_PADZ;
                end
            end
            ST_PADZ:
            begin
                if (status.fill_len)
                begin
                    state_next = ST_LENHI;
                end
                else
                begin
                    cmd.push_byte = 1'b1;
                    cmd.byte_sel  = BSEL_ZERO;
                    if (status.fill_full)
                    begin
                        state_next = ST_LOAD;
                        count_next = 1'b0;
                        ret_next   = RET_PADZ;
                    end
                end
            end
            ST_LENHI:
            begin
                cmd.push_len_hi = 1'b1;
                state_next      = ST_LENLO;
            end
            ST_LENLO:
            begin
                cmd.push_len_lo = 1'b1;
                state_next      = ST_LOAD;
                count_next      = 1'b0;
                ret_next        = RET_OUT;
            end
            ST_LOAD:
            begin
                cmd.comp_load = 1'b1;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.comp_round = 1'b1;
                if (status.round_last)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                cmd.comp_add    = 1'b1;
                cmd.count_block = count_reg;
                unique case (ret_reg)
                    RET_IDLE:  state_next = ST_IDLE;
                    RET_PAD80: state_next = ST_PAD80;
                    RET_PADZ:  state_next = ST_PADZ;
                    default:   state_next = ST_OUT;
                endcase
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    cmd.out_next = 1'b1;
                    if (status.out_last)
                    begin
                        cmd.reinit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/sha512_datapath.sv]
// ----------------------------------------------------------------------------
// sha512_datapath
// word packing, message schedule window, round unit and chaining value
// ----------------------------------------------------------------------------
module sha512_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             in_byte,
    input  sha512_pkg::dp_cmd_t    cmd,
    output sha512_pkg::dp_status_t status,
    output logic [63:0]            digest_word,
    output logic [2:0]             word_index,
    output logic                   last_word
);
    import sha512_pkg::*;

    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [63:0]        count_reg, count_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [2:0]         idx_reg, idx_next;
    logic [FILL_W-1:0]  rest_reg;
    logic [55:0]        acc_reg;
    logic [63:0]        w_reg [16];
    logic [63:0]        v_reg [8];
    logic [63:0]        h_reg [8];

    logic [7:0]  push_val;
    logic [63:0] push_word;
    logic        word_shift;
    logic [63:0] sched_word;
    logic [63:0] t1, t2;
    logic [63:0] len_hi, len_lo;

    always_comb
    begin
        unique case (cmd.byte_sel)
            BSEL_PAD:  push_val = PAD_BYTE;
            BSEL_ZERO: push_val = 8'h00;
            default:   push_val = in_byte;
        endcase
    end

    // bit length: block count times 1024 plus the tail bytes times 8
    assign len_hi = {54'd0, count_reg[63:54]};
    assign len_lo = {count_reg[53:0], rest_reg, 3'b000};

    always_comb
    begin
        word_shift = 1'b0;
        push_word  = {acc_reg, push_val};
        if (cmd.push_byte && (fill_reg[2:0] == 3'd7))
        begin
            word_shift = 1'b1;
        end
        if (cmd.push_len_hi)
        begin
            word_shift = 1'b1;
            push_word  = len_hi;
        end
        if (cmd.push_len_lo)
        begin
            word_shift = 1'b1;
            push_word  = len_lo;
        end
    end

    assign sched_word = w_reg[0]
                      + (rotr64(w_reg[1], 1) ^ rotr64(w_reg[1], 8) ^ (w_reg[1] >> 7))
                      + w_reg[9]
                      + (rotr64(w_reg[14], 19) ^ rotr64(w_reg[14], 61) ^ (w_reg[14] >> 6));

    assign t1 = v_reg[7]
              + (rotr64(v_reg[4], 14) ^ rotr64(v_reg[4], 18) ^ rotr64(v_reg[4], 41))
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + round_k(round_reg) + w_reg[0];
    assign t2 = (rotr64(v_reg[0], 28) ^ rotr64(v_reg[0], 34) ^ rotr64(v_reg[0], 39))
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb
    begin
        fill_next  = fill_reg;
        count_next = count_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        if (cmd.push_byte)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        if (cmd.push_len_hi || cmd.push_len_lo)
        begin
            fill_next = fill_reg + FILL_W'(8);
        end
        if (cmd.count_block)
        begin
            count_next = count_reg + 64'd1;
        end
        if (cmd.comp_load)
        begin
            round_next = '0;
        end
        else if (cmd.comp_round)
        begin
            round_next = round_reg + ROUND_W'(1);
        end
        if (cmd.out_next)
        begin
            idx_next = idx_reg + 3'd1;
        end
        if (cmd.reinit)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            count_reg <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            count_reg <= count_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
        end
    end

    // chaining value resets to the initial hash
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= iv_word(3'(i));
            end
        end
        else if (cmd.reinit)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= iv_word(3'(i));
            end
        end
        else if (cmd.comp_add)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_byte)
        begin
            acc_reg <= {acc_reg[47:0], push_val};
        end
        if (cmd.capture_rest)
        begin
            rest_reg <= fill_reg;
        end
        if (word_shift || cmd.comp_round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= cmd.comp_round ? sched_word : push_word;
        end
        if (cmd.comp_load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (cmd.comp_round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign status.fill_full  = (fill_reg == FILL_FULL);
    assign status.fill_len   = (fill_reg == FILL_LEN);
    assign status.round_last = (round_reg == ROUND_LAST);
    assign status.out_last   = (idx_reg == 3'd7);

    assign digest_word = h_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd7);

endmodule
